>>> src/wnca_pkg.sv
// ----------------------------------------------------------------------------
// wnca_pkg
// Shared codes, sequencer states and the cell control word of the
// weighted nearest-centre assignment core.
// ----------------------------------------------------------------------------
`default_nettype none

package wnca_pkg;

	typedef enum logic [1:0] {
		OP_SAMPLE  = 2'd0,
		OP_CENTER  = 2'd1,
		OP_FWEIGHT = 2'd2,
		OP_GWEIGHT = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_GW,
		ST_WM,
		ST_P0,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_ACC,
		ST_CMP,
		ST_OUT
	} state_t;

	// control word broadcast to every cell
	typedef struct packed {
		logic       ad;      // register |centre - sample|
		logic       sq;      // square the difference
		logic       pp;      // partial product step
		logic [1:0] pp_sel;  // which partial product
		logic       acc;     // saturating add into the accumulator
		logic       clr;     // clear accumulator
	} cell_ctl_t;

	localparam logic [4:0] ACTIVE_RESET = 5'd16;

endpackage

`default_nettype wire

>>> src/wnca_cell.sv
// ----------------------------------------------------------------------------
// wnca_cell
// One cluster: centre row, distance accumulator and one stage of the
// minimum-search chain.
// ----------------------------------------------------------------------------
`default_nettype none

module wnca_cell #(
	parameter int IDX = 0,
	parameter int MAX_FEATURES = 64,
	parameter int VALUE_WIDTH = 32,
	parameter int FA = 6,
	parameter int CW = 5,
	parameter int CIW = 4
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire wnca_pkg::cell_ctl_t   ctl,
	input  wire                        wr_en,
	input  wire  [FA-1:0]              wr_addr,
	input  wire  [VALUE_WIDTH-1:0]     wr_data,
	input  wire  [FA-1:0]              rd_addr,
	input  wire  [VALUE_WIDTH-1:0]     smp,
	input  wire  [2*VALUE_WIDTH-3:0]   w,
	input  wire  [CW-1:0]              act_n,
	input  wire  [CIW-1:0]             tok_idx_in,
	input  wire  [63:0]                tok_dist_in,
	output logic [CIW-1:0]             tok_idx_out,
	output logic [63:0]                tok_dist_out
);
	import wnca_pkg::*;

	localparam int VW = VALUE_WIDTH;
	localparam int PW = (4*VW-2 > 96) ? 4*VW-2 : 97;

	logic [VW-1:0]   mem [MAX_FEATURES];
	logic [VW-1:0]   cen_q;
	logic [VW-1:0]   ad_q;
	logic [2*VW-1:0] sq_q;
	logic [PW-1:0]   p_q;
	logic [63:0]     acc_q;

	logic [VW:0]     d;
	logic [VW:0]     dn;
	logic [VW-1:0]   ma, mb;
	logic [2*VW-1:0] prod;
	logic [PW-1:0]   pp_sh;
	logic [63:0]     term;
	logic [64:0]     sum;
	logic            take;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		cen_q <= mem[rd_addr];
	end

	assign d  = {cen_q[VW-1], cen_q} - {smp[VW-1], smp};
	assign dn = -d;

	always_comb begin
		ma = ad_q;
		mb = ad_q;
		if (ctl.pp) begin
			case (ctl.pp_sel)
				2'd0: begin ma = w[VW-1:0];            mb = sq_q[VW-1:0];    end
				2'd1: begin ma = w[VW-1:0];            mb = sq_q[2*VW-1:VW]; end
				2'd2: begin ma = VW'(w[2*VW-3:VW]);    mb = sq_q[VW-1:0];    end
				default: begin ma = VW'(w[2*VW-3:VW]); mb = sq_q[2*VW-1:VW]; end
			endcase
		end
	end

	assign prod = ma * mb;

	always_comb begin
		case (ctl.pp_sel)
			2'd0:    pp_sh = PW'(prod);
			2'd1:    pp_sh = PW'(prod) << VW;
			2'd2:    pp_sh = PW'(prod) << VW;
			default: pp_sh = PW'(prod) << (2*VW);
		endcase
	end

	// floor(P / 2^32), saturated to 64 bits
	assign term = (|p_q[PW-1:96]) ? {64{1'b1}} : p_q[95:32];
	assign sum  = {1'b0, acc_q} + {1'b0, term};

	always_ff @(posedge clk) begin
		if (ctl.ad) begin
			ad_q <= d[VW] ? dn[VW-1:0] : d[VW-1:0];
		end
		if (ctl.sq) begin
			sq_q <= prod;
		end
		if (ctl.pp) begin
			p_q <= (ctl.pp_sel == 2'd0) ? pp_sh : p_q + pp_sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.acc) begin
			acc_q <= sum[64] ? {64{1'b1}} : sum[63:0];
		end
	end

	// ties go to the higher index, so <= lets a later cell win
	assign take = (IDX == 0) || ((32'(act_n) > IDX) && (acc_q <= tok_dist_in));

	always_ff @(posedge clk) begin
		tok_idx_out  <= take ? CIW'(IDX) : tok_idx_in;
		tok_dist_out <= take ? acc_q : tok_dist_in;
	end

endmodule

`default_nettype wire

>>> src/weighted_nearest_center_assign_core.sv
// ----------------------------------------------------------------------------
// weighted_nearest_center_assign_core
// Assignment step of two-level weighted k-means over a chain of cluster cells.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (in_valid/in_ready) carries load items and feature samples.
//   Operation selects: sample, centre element, feature weight with group,
//   group weight. Loads are written at acceptance; the core stays idle.
//   A sample runs through acceptance, store reads, group weight read with
//   difference, weight product with square, four partial products of the
//   per-cell multiplier, saturating accumulate; no new item is taken until
//   it is done. The single multiplier per cell does the square and each product.
//   A sample marked last then holds the compare step while the running minimum
//   walks the cell chain, then the output step loads the output register.
//   Output channel (out_valid/out_ready) holds best_cluster and
//   best_distance in a register; a new item is taken while it waits, but a
//   further last sample stalls in the output step until the slot is free.
//   cfg_we/cfg_wdata write active_clusters; the user must write it while idle.
//   Reset: accumulators cleared, active_clusters = 16, stores undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_nearest_center_assign_core #(
	parameter int MAX_CLUSTERS = 16,
	parameter int MAX_FEATURES = 64,
	parameter int MAX_GROUPS = 8,
	parameter int VALUE_WIDTH = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [1:0]  operation,
	input  wire  [3:0]  cluster_slot,
	input  wire  [5:0]  feature_slot,
	input  wire  [2:0]  group_slot,
	input  wire  [31:0] value,
	input  wire         last_feature,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [3:0]  best_cluster,
	output logic [63:0] best_distance,
	input  wire         cfg_we,
	input  wire  [4:0]  cfg_wdata
);
	import wnca_pkg::*;

	localparam int VW  = VALUE_WIDTH;
	localparam int FA  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int FSW = (FA > 6) ? FA : 6;
	localparam int GA  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int GSW = (GA > 3) ? GA : 3;
	localparam int CW  = $clog2(MAX_CLUSTERS + 1);
	localparam int CIW = $clog2(MAX_CLUSTERS);
	localparam int OW  = (CIW > 4) ? CIW : 4;

	state_t    state_q, state_d;
	cell_ctl_t ctl;

	logic [4:0]        active_q;
	logic [CW-1:0]     act_n;
	logic [CW-1:0]     cnt_q;
	logic [FA-1:0]     fa_q;
	logic              infeat_q;
	logic              last_q;
	logic [VW-1:0]     val_q;
	logic [2*VW-3:0]   w_q;
	logic              out_valid_q;
	logic [3:0]        best_cluster_q;
	logic [63:0]       best_distance_q;

	logic [VW-1:0]     fw_mem [MAX_FEATURES];
	logic [2:0]        grp_mem [MAX_FEATURES];
	logic [VW-1:0]     gw_mem [MAX_GROUPS];
	logic [VW-1:0]     fw_rd_q;
	logic [2:0]        grp_rd_q;
	logic [VW-1:0]     gw_rd_q;

	logic              accept;
	logic [FSW-1:0]    fs_ext;
	logic [GSW-1:0]    gs_ext;
	logic [GSW-1:0]    gr_ext;
	logic              fs_ok, gs_ok, cs_ok;
	logic              out_free;
	logic [VW-2:0]     fwp, gwp;
	logic [OW-1:0]     best_ext;

	logic [CIW-1:0]    tok_idx  [MAX_CLUSTERS+1];
	logic [63:0]       tok_dist [MAX_CLUSTERS+1];

	assign accept   = in_valid && in_ready;
	assign fs_ext   = FSW'(feature_slot);
	assign gs_ext   = GSW'(group_slot);
	assign gr_ext   = GSW'(grp_rd_q);
	assign fs_ok    = 32'(feature_slot) < MAX_FEATURES;
	assign gs_ok    = 32'(group_slot) < MAX_GROUPS;
	assign cs_ok    = 32'(cluster_slot) < MAX_CLUSTERS;
	assign out_free = !out_valid_q || out_ready;

	// clamp of the active count: 0 acts as 1, top saturates
	always_comb begin
		if (active_q == 5'd0) begin
			act_n = CW'(1);
		end else if (32'(active_q) > MAX_CLUSTERS) begin
			act_n = CW'(MAX_CLUSTERS);
		end else begin
			act_n = CW'(active_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	// weight stores, registered reads
	always_ff @(posedge clk) begin
		if (accept && op_t'(operation) == OP_FWEIGHT && fs_ok && gs_ok) begin
			fw_mem[fs_ext[FA-1:0]]  <= value[VW-1:0];
			grp_mem[fs_ext[FA-1:0]] <= group_slot;
		end
		if (accept && op_t'(operation) == OP_GWEIGHT && gs_ok) begin
			gw_mem[gs_ext[GA-1:0]] <= value[VW-1:0];
		end
		fw_rd_q  <= fw_mem[fa_q];
		grp_rd_q <= grp_mem[fa_q];
		gw_rd_q  <= gw_mem[gr_ext[GA-1:0]];
	end

	// negative weights act as zero
	assign fwp = fw_rd_q[VW-1] ? '0 : fw_rd_q[VW-2:0];
	assign gwp = gw_rd_q[VW-1] ? '0 : gw_rd_q[VW-2:0];

	// sample capture and combined weight
	always_ff @(posedge clk) begin
		if (accept && op_t'(operation) == OP_SAMPLE) begin
			fa_q     <= fs_ext[FA-1:0];
			infeat_q <= fs_ok;
			last_q   <= last_feature;
			val_q    <= value[VW-1:0];
		end
		if (state_q == ST_WM) begin
			w_q <= fwp * gwp;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_q == ST_CMP) ? cnt_q + CW'(1) : '0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && op_t'(operation) == OP_SAMPLE) state_d = ST_RD;
			ST_RD:   state_d = ST_GW;
			ST_GW:   state_d = ST_WM;
			ST_WM:   state_d = ST_P0;
			ST_P0:   state_d = ST_P1;
			ST_P1:   state_d = ST_P2;
			ST_P2:   state_d = ST_P3;
			ST_P3:   state_d = ST_ACC;
			ST_ACC:  state_d = last_q ? ST_CMP : ST_IDLE;
			ST_CMP:  if (cnt_q == CW'(MAX_CLUSTERS - 1)) state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_GW:   ctl.ad = 1'b1;
			ST_WM:   ctl.sq = 1'b1;
			ST_P0:   begin ctl.pp = 1'b1; ctl.pp_sel = 2'd0; end
			ST_P1:   begin ctl.pp = 1'b1; ctl.pp_sel = 2'd1; end
			ST_P2:   begin ctl.pp = 1'b1; ctl.pp_sel = 2'd2; end
			ST_P3:   begin ctl.pp = 1'b1; ctl.pp_sel = 2'd3; end
			ST_ACC:  ctl.acc = infeat_q;
			ST_OUT:  ctl.clr = out_free;
			default: ctl = '0;
		endcase
	end

	// cell chain: token enters at cell 0, result leaves the last cell
	assign tok_idx[0]  = '0;
	assign tok_dist[0] = '0;

	for (genvar c = 0; c < MAX_CLUSTERS; c++) begin : g_cell
		wnca_cell #(
			.IDX(c),
			.MAX_FEATURES(MAX_FEATURES),
			.VALUE_WIDTH(VALUE_WIDTH),
			.FA(FA),
			.CW(CW),
			.CIW(CIW)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.wr_en(accept && op_t'(operation) == OP_CENTER && fs_ok && cs_ok
				&& 32'(cluster_slot) == c),
			.wr_addr(fs_ext[FA-1:0]),
			.wr_data(value[VW-1:0]),
			.rd_addr(fa_q),
			.smp(val_q),
			.w(w_q),
			.act_n(act_n),
			.tok_idx_in(tok_idx[c]),
			.tok_dist_in(tok_dist[c]),
			.tok_idx_out(tok_idx[c+1]),
			.tok_dist_out(tok_dist[c+1])
		);
	end

	assign best_ext = OW'(tok_idx[MAX_CLUSTERS]);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			best_cluster_q  <= best_ext[3:0];
			best_distance_q <= tok_dist[MAX_CLUSTERS];
		end
	end

	assign out_valid     = out_valid_q;
	assign best_cluster  = best_cluster_q;
	assign best_distance = best_distance_q;

`ifndef SYNTHESIS
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> (out_valid && state_q == ST_IDLE))
		else $error("result not loaded on leaving output step");
	a_cmp_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |=> (state_q == ST_CMP || state_q == ST_OUT))
		else $error("minimum search left early");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(best_distance)))
		else $error("stalled result changed");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!ctl.pp && !ctl.acc))
		else $error("arithmetic step while idle");
`endif

endmodule

`default_nettype wire

>>> tb/weighted_nearest_center_assign_core_test.sv
// ----------------------------------------------------------------------------
// weighted_nearest_center_assign_core_test
// Self-checking bench: fills every store, walks a table of directed items,
// then streams random points with interleaved loads. A predictor of the
// weighted distance sums holds the expected item for each last sample.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_nearest_center_assign_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import wnca_pkg::*;

	localparam int NCL = 16;
	localparam int NFT = 64;
	localparam int NGR = 8;
	localparam logic [63:0] SAT = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [31:0] ONE = 32'h0001_0000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  operation;
	logic [3:0]  cluster_slot;
	logic [5:0]  feature_slot;
	logic [2:0]  group_slot;
	logic [31:0] value;
	logic        last_feature;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  best_cluster;
	logic [63:0] best_distance;
	logic        cfg_we;
	logic [4:0]  cfg_wdata;

	weighted_nearest_center_assign_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .cluster_slot(cluster_slot),
		.feature_slot(feature_slot), .group_slot(group_slot),
		.value(value), .last_feature(last_feature),
		.out_valid(out_valid), .out_ready(out_ready),
		.best_cluster(best_cluster), .best_distance(best_distance),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	typedef struct {
		logic [3:0]  cl;
		logic [63:0] distance;
	} nearest_t;

	typedef struct {
		op_t         op;
		logic [3:0]  cl;
		logic [5:0]  fs;
		logic [2:0]  gs;
		logic [31:0] val;
		logic        last;
		logic        typed;   // expectation given in the row itself
		logic [3:0]  exp_cl;
		logic [63:0] exp_dist;
	} row_t;

	// shadow state of the core
	logic signed [31:0] centre_m [NCL][NFT];
	logic signed [31:0] fweight_m [NFT];
	logic [2:0]         fgroup_m [NFT];
	logic signed [31:0] gweight_m [NGR];
	logic [63:0]        dist_m [NCL];
	logic [4:0]         active_m;

	nearest_t nearest_q [$];
	int       mismatches;
	int       burst_left;
	int       rdy_left;
	logic     rdy_mode;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit, far beyond the slowest legal run
	initial begin
		#12ms;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? SAT : s[63:0];
	endfunction

	// (w * sq) >> 32, floored, clamped at the 64-bit maximum
	function automatic logic [63:0] weighted_term(input logic [63:0] w, input logic [63:0] sq);
		logic [127:0] p;
		p = {64'd0, w} * {64'd0, sq};
		return (p[127:96] != 0) ? SAT : p[95:32];
	endfunction

	function automatic logic [63:0] pos_weight(input logic signed [31:0] w);
		return (w < 0) ? 64'd0 : {32'd0, w};
	endfunction

	// Updates the shadow state for one accepted item; queues the nearest
	// cluster on a last sample (typed rows override the computed values).
	task automatic predict_item(input row_t r);
		logic [63:0] w, sq, bd, ad;
		logic signed [32:0] d;
		logic [4:0] n;
		logic [3:0] best;
		nearest_t e;
		case (r.op)
			OP_CENTER: centre_m[r.cl][r.fs] = r.val;
			OP_FWEIGHT: begin
				fweight_m[r.fs] = r.val;
				fgroup_m[r.fs] = r.gs;
			end
			OP_GWEIGHT: gweight_m[r.gs] = r.val;
			default: begin
				w = pos_weight(fweight_m[r.fs]) * pos_weight(gweight_m[fgroup_m[r.fs]]);
				for (int c = 0; c < NCL; c++) begin
					d = $signed({centre_m[c][r.fs][31], centre_m[c][r.fs]})
						- $signed({r.val[31], r.val});
					ad = (d < 0) ? {31'd0, -d} : {31'd0, d};
					sq = ad * ad;
					dist_m[c] = sat_sum(dist_m[c], weighted_term(w, sq));
				end
				if (r.last) begin
					n = (active_m == 0) ? 5'd1 : (active_m > NCL) ? 5'(NCL) : active_m;
					best = 0;
					bd = dist_m[0];
					for (int c = 1; c < n; c++)
						if (dist_m[c] <= bd) begin
							bd = dist_m[c];
							best = 4'(c);
						end
					e.cl = r.typed ? r.exp_cl : best;
					e.distance = r.typed ? r.exp_dist : bd;
					nearest_q.push_back(e);
					for (int c = 0; c < NCL; c++)
						dist_m[c] = 64'd0;
				end
			end
		endcase
	endtask

	// Presents one item, waits for acceptance, then maybe idles for a gap.
	task automatic send_item(input row_t r);
		in_valid <= 1'b1;
		operation <= r.op;
		cluster_slot <= r.cl;
		feature_slot <= r.fs;
		group_slot <= r.gs;
		value <= r.val;
		last_feature <= r.last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_item(r);
		if (burst_left > 0)
			burst_left--;
		else begin
			burst_left = $urandom_range(0, 30);
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
		end
	endtask

	function automatic row_t mk(input op_t op, input logic [3:0] cl, input logic [5:0] fs,
			input logic [2:0] gs, input logic [31:0] val, input logic last);
		row_t r;
		r.op = op; r.cl = cl; r.fs = fs; r.gs = gs; r.val = val; r.last = last;
		r.typed = 1'b0; r.exp_cl = 0; r.exp_dist = 0;
		return r;
	endfunction

	function automatic row_t mk_typed(input logic [5:0] fs, input logic [31:0] val,
			input logic [3:0] ecl, input logic [63:0] ed);
		row_t r;
		r = mk(OP_SAMPLE, 4'($urandom), fs, 3'($urandom), val, 1'b1);
		r.typed = 1'b1; r.exp_cl = ecl; r.exp_dist = ed;
		return r;
	endfunction

	// Waits for the last item, lets the core settle, then writes the register.
	task automatic set_active(input logic [4:0] n);
		in_valid <= 1'b0;
		@(posedge clk);
		while (nearest_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we <= 1'b0;
		active_m = n;
	endtask

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
		endcase
	endfunction

	function automatic logic [31:0] rand_weight();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000 | $urandom;
			default: return $urandom_range(0, 2 << 16);
		endcase
	endfunction

	// Receiver: alternating ready and stall stretches, sometimes long ready runs.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rdy_left <= 0;
			rdy_mode <= 1'b0;
		end else if (rdy_left == 0) begin
			rdy_mode <= ~rdy_mode;
			rdy_left <= rdy_mode ? $urandom_range(1, 25)
				: (($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 40));
			out_ready <= ~rdy_mode;
		end else
			rdy_left <= rdy_left - 1;
	end

	// Result checker against the oldest expectation.
	always @(posedge clk) begin
		nearest_t e;
		if (arst_n && out_valid && out_ready) begin
			if (nearest_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: cluster %0d distance %h",
						best_cluster, best_distance);
			end else begin
				e = nearest_q.pop_front();
				if (best_cluster !== e.cl || best_distance !== e.distance) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: cluster exp %0d got %0d, distance exp %h got %h",
							e.cl, best_cluster, e.distance, best_distance);
				end
			end
		end
	end

	initial begin
		row_t dir [$];
		row_t r;
		int npts;
		int len;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_SAMPLE;
		cluster_slot = 0;
		feature_slot = 0;
		group_slot = 0;
		value = 0;
		last_feature = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 0;
		mismatches = 0;
		burst_left = 0;
		active_m = ACTIVE_RESET;
		for (int c = 0; c < NCL; c++)
			dist_m[c] = 64'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every entry is written before any sample reads it; weights start at zero
		for (int f = 0; f < NFT; f++)
			send_item(mk(OP_FWEIGHT, 4'($urandom), 6'(f), 3'(f), 32'd0, 1'($urandom)));
		for (int g = 0; g < NGR; g++)
			send_item(mk(OP_GWEIGHT, 4'($urandom), 6'($urandom), 3'(g), 32'd0, 1'($urandom)));
		for (int c = 0; c < NCL; c++)
			for (int f = 0; f < NFT; f++)
				send_item(mk(OP_CENTER, 4'(c), 6'(f), 3'($urandom), 32'd0, 1'($urandom)));

		// zero weights: all tie, highest active index wins
		dir.push_back(mk_typed(6'd0, 32'h1234_5678, 4'd15, 64'd0));
		dir.push_back(mk(OP_GWEIGHT, 0, 0, 3'd0, 32'h7FFF_FFFF, 1'b1));
		dir.push_back(mk(OP_FWEIGHT, 0, 6'd0, 3'd0, 32'h7FFF_FFFF, 1'b0));
		dir.push_back(mk(OP_CENTER, 4'd3, 6'd0, 3'd7, 32'h8000_0000, 1'b1));
		// largest weights and differences: every sum saturates
		dir.push_back(mk_typed(6'd0, 32'h7FFF_FFFF, 4'd15, SAT));
		// negative feature weight acts as zero
		dir.push_back(mk(OP_FWEIGHT, 0, 6'd0, 3'd0, 32'hFFFF_FFFF, 1'b0));
		dir.push_back(mk_typed(6'd0, 32'h8000_0000, 4'd15, 64'd0));
		// unit weights, centre 5 matches the sample exactly
		dir.push_back(mk(OP_FWEIGHT, 0, 6'd0, 3'd0, ONE, 1'b0));
		dir.push_back(mk(OP_GWEIGHT, 0, 0, 3'd0, ONE, 1'b0));
		dir.push_back(mk(OP_CENTER, 4'd5, 6'd0, 0, ONE, 1'b0));
		dir.push_back(mk(OP_CENTER, 4'd15, 6'd0, 0, 32'h0002_0000, 1'b0));
		dir.push_back(mk_typed(6'd0, ONE, 4'd5, 64'd0));
		// negative group weight acts as zero
		dir.push_back(mk(OP_GWEIGHT, 0, 0, 3'd7, 32'h8000_0000, 1'b0));
		dir.push_back(mk(OP_FWEIGHT, 0, 6'd63, 3'd7, 32'h7FFF_FFFF, 1'b0));
		dir.push_back(mk(OP_CENTER, 4'd0, 6'd63, 0, 32'h7FFF_FFFF, 1'b0));
		dir.push_back(mk(OP_SAMPLE, 4'd15, 6'd63, 3'd7, 32'h8000_0000, 1'b0));
		dir.push_back(mk(OP_SAMPLE, 0, 6'd0, 0, 32'h0003_0000, 1'b0));
		dir.push_back(mk(OP_SAMPLE, 0, 6'd0, 0, 32'hFFFF_0000, 1'b1));
		foreach (dir[i])
			send_item(dir[i]);

		// single active cluster: always cluster 0
		set_active(5'd1);
		send_item(mk(OP_SAMPLE, 0, 6'd0, 0, ONE, 1'b0));
		r = mk_typed(6'd0, 32'h0000_8000, 4'd0, 64'd0);
		r.typed = 1'b0;
		send_item(r);

		npts = 0;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_active(5'd0);
				1: set_active(5'd31);
				2: set_active(5'd16);
				3: set_active(5'd2);
				4: set_active(5'd17);
				default: set_active(5'($urandom_range(3, 15)));
			endcase
			// some fresh weights so distances differ between clusters
			for (int k = 0; k < 20; k++) begin
				send_item(mk(OP_FWEIGHT, 4'($urandom), 6'($urandom), 3'($urandom),
					rand_weight(), 1'($urandom)));
				send_item(mk(OP_GWEIGHT, 4'($urandom), 6'($urandom), 3'($urandom),
					rand_weight(), 1'($urandom)));
			end
			for (int p = 0; p < 25; p++) begin
				len = $urandom_range(1, 6);
				for (int s = 0; s < len; s++) begin
					if ($urandom_range(0, 9) == 0)
						send_item(mk(op_t'($urandom_range(1, 3)), 4'($urandom), 6'($urandom),
							3'($urandom), ($urandom_range(0, 1) ? rand_weight() : rand_sample()),
							1'($urandom)));
					send_item(mk(OP_SAMPLE, 4'($urandom), 6'($urandom), 3'($urandom),
						rand_sample(), (s == len - 1)));
				end
				npts++;
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (nearest_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
